/* rtl/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasterizer
// Coordinate widths, item kinds and the records that pass from the setup
// front end to the stepping back end and from there to the pixel queue.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

	// coordinate and arithmetic widths
	localparam int CoordBits  = 12;
	localparam int IncBits    = CoordBits + 2;
	localparam int ErrBits    = CoordBits + 3;
	localparam int ColorBits  = 32;

	// queue geometry (depth is a power of two so the pointers wrap freely)
	localparam int QueueDepth = 2;
	localparam int PtrBits    = $clog2(QueueDepth);
	localparam int CntBits    = $clog2(QueueDepth + 1);

	// item kinds
	localparam logic KindStart = 1'b0;
	localparam logic KindStep  = 1'b1;

	typedef logic [CoordBits-1:0] coord_t;

	// classified item handed from the front end to the back end
	typedef struct packed {
		logic                       kind;
		coord_t                     x0;
		coord_t                     y0;
		coord_t                     steps;
		logic                       x_major;
		logic                       x_neg;
		logic [IncBits-1:0]         inc_straight;
		logic signed [ErrBits-1:0]  inc_diagonal;
		logic signed [ErrBits-1:0]  err_init;
		logic [ColorBits-1:0]       color;
	} cmd_t;

	// one emitted pixel
	typedef struct packed {
		coord_t                x;
		coord_t                y;
		logic [ColorBits-1:0]  value;
		logic                  last;
	} pixel_t;

endpackage

`default_nettype wire

/* rtl/lr_front.sv */
// ----------------------------------------------------------------------------
// lr_front: input stage and line setup
// Registers each incoming transaction, orders the endpoints so y never
// decreases, and derives step direction, major axis and error constants.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         kind,
	input  wire lr_pkg::coord_t               start_x,
	input  wire lr_pkg::coord_t               start_y,
	input  wire lr_pkg::coord_t               end_x,
	input  wire lr_pkg::coord_t               end_y,
	input  wire logic [lr_pkg::ColorBits-1:0] line_color,
	output logic                              cmd_valid,
	output lr_pkg::cmd_t                      cmd,
	input  wire logic                         cmd_ready
);

	logic                              valid_s1;
	logic                              kind_s1;
	lr_pkg::coord_t                    x1_s1;
	lr_pkg::coord_t                    y1_s1;
	lr_pkg::coord_t                    x2_s1;
	lr_pkg::coord_t                    y2_s1;
	logic [lr_pkg::ColorBits-1:0]      color_s1;

	logic                              advance;
	logic                              swap;
	lr_pkg::coord_t                    xa;
	lr_pkg::coord_t                    ya;
	lr_pkg::coord_t                    xb;
	lr_pkg::coord_t                    yb;
	logic                              x_neg;
	lr_pkg::coord_t                    adx;
	lr_pkg::coord_t                    dy;
	logic                              x_major;
	lr_pkg::coord_t                    major;
	lr_pkg::coord_t                    minor;

	// stage moves when empty or when the queue takes its transaction
	assign advance   = !valid_s1 || cmd_ready;
	assign full      = !advance;
	assign cmd_valid = valid_s1;

	// hold the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			kind_s1  <= kind;
			x1_s1    <= start_x;
			y1_s1    <= start_y;
			x2_s1    <= end_x;
			y2_s1    <= end_y;
			color_s1 <= line_color;
		end
	end

	// order endpoints, take differences and pick the major axis
	always_comb begin
		swap    = y1_s1 > y2_s1;
		xa      = swap ? x2_s1 : x1_s1;
		ya      = swap ? y2_s1 : y1_s1;
		xb      = swap ? x1_s1 : x2_s1;
		yb      = swap ? y1_s1 : y2_s1;
		x_neg   = !(xb > xa);
		adx     = x_neg ? (xa - xb) : (xb - xa);
		dy      = yb - ya;
		x_major = adx > dy;
		major   = x_major ? adx : dy;
		minor   = x_major ? dy : adx;
	end

	// build the classified command
	always_comb begin
		cmd.kind         = kind_s1;
		cmd.x0           = xa;
		cmd.y0           = ya;
		cmd.steps        = major;
		cmd.x_major      = x_major;
		cmd.x_neg        = x_neg;
		cmd.inc_straight = {1'b0, minor, 1'b0};
		cmd.inc_diagonal = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
		cmd.err_init     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
		cmd.color        = color_s1;
	end

endmodule

`default_nettype wire

/* rtl/lr_queue.sv */
// ----------------------------------------------------------------------------
// lr_queue: command queue between front end and back end
// Small register queue that lets the setup stage and the stepping stage
// stall independently of each other.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	input  wire lr_pkg::cmd_t  wr_data,
	output logic               wr_ready,
	output logic               rd_valid,
	output lr_pkg::cmd_t       rd_data,
	input  wire logic          rd_en
);

	lr_pkg::cmd_t                  mem_q [lr_pkg::QueueDepth];
	logic [lr_pkg::PtrBits-1:0]    wr_ptr_q;
	logic [lr_pkg::PtrBits-1:0]    rd_ptr_q;
	logic [lr_pkg::CntBits-1:0]    count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign wr_ready = count_q < lr_pkg::CntBits'(lr_pkg::QueueDepth);
	assign rd_valid = count_q != '0;
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	// store the written transaction
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/lr_back.sv */
// ----------------------------------------------------------------------------
// lr_back: Bresenham stepper and pixel queue
// Holds the active line, advances it by one pixel per step command and
// queues the emitted pixels for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cmd_valid,
	input  wire lr_pkg::cmd_t                 cmd,
	output logic                              cmd_rd,
	output logic                              empty,
	input  wire logic                         pop,
	output lr_pkg::coord_t                    pixel_x,
	output lr_pkg::coord_t                    pixel_y,
	output logic [lr_pkg::ColorBits-1:0]      pixel_value,
	output logic                              last
);

	// line state
	logic                                 busy_q;
	lr_pkg::coord_t                       cur_x_q;
	lr_pkg::coord_t                       cur_y_q;
	lr_pkg::coord_t                       steps_q;
	logic signed [lr_pkg::ErrBits-1:0]    err_q;
	logic [lr_pkg::IncBits-1:0]           inc_straight_q;
	logic signed [lr_pkg::ErrBits-1:0]    inc_diagonal_q;
	logic                                 x_major_q;
	logic                                 x_neg_q;
	logic [lr_pkg::ColorBits-1:0]         color_q;

	// pixel queue
	lr_pkg::pixel_t                       pix_mem_q [lr_pkg::QueueDepth];
	logic [lr_pkg::PtrBits-1:0]           pix_wr_ptr_q;
	logic [lr_pkg::PtrBits-1:0]           pix_rd_ptr_q;
	logic [lr_pkg::CntBits-1:0]           pix_count_q;

	logic                                 room;
	logic                                 is_start;
	logic                                 produce;
	logic                                 do_pop;
	logic                                 minor_move;
	lr_pkg::coord_t                       x_adv;
	lr_pkg::coord_t                       nx;
	lr_pkg::coord_t                       ny;
	logic signed [lr_pkg::ErrBits-1:0]    n_err;
	lr_pkg::coord_t                       n_steps;
	lr_pkg::pixel_t                       pix;
	lr_pkg::pixel_t                       head;

	assign room     = pix_count_q < lr_pkg::CntBits'(lr_pkg::QueueDepth);
	assign cmd_rd   = cmd_valid && room;
	assign is_start = cmd.kind == lr_pkg::KindStart;
	assign produce  = cmd_rd && (is_start || busy_q);
	assign empty    = pix_count_q == '0;
	assign do_pop   = pop && !empty;

	// compute the next pixel of the active line
	always_comb begin
		minor_move = !err_q[lr_pkg::ErrBits-1];
		x_adv      = x_neg_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
		n_err      = minor_move ? (err_q + inc_diagonal_q)
		                        : (err_q + $signed({1'b0, inc_straight_q}));
		if (x_major_q) begin
			nx = x_adv;
			ny = minor_move ? (cur_y_q + 1'b1) : cur_y_q;
		end else begin
			nx = minor_move ? x_adv : cur_x_q;
			ny = cur_y_q + 1'b1;
		end
		n_steps = steps_q - 1'b1;
		if (is_start) begin
			pix.x     = cmd.x0;
			pix.y     = cmd.y0;
			pix.value = cmd.color;
			pix.last  = cmd.steps == '0;
		end else begin
			pix.x     = nx;
			pix.y     = ny;
			pix.value = color_q;
			pix.last  = n_steps == '0;
		end
	end

	// load a new line or advance the active one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			cur_x_q        <= '0;
			cur_y_q        <= '0;
			steps_q        <= '0;
			err_q          <= '0;
			inc_straight_q <= '0;
			inc_diagonal_q <= '0;
			x_major_q      <= 1'b0;
			x_neg_q        <= 1'b0;
			color_q        <= '0;
		end else if (produce) begin
			if (is_start) begin
				busy_q         <= cmd.steps != '0;
				cur_x_q        <= cmd.x0;
				cur_y_q        <= cmd.y0;
				steps_q        <= cmd.steps;
				err_q          <= cmd.err_init;
				inc_straight_q <= cmd.inc_straight;
				inc_diagonal_q <= cmd.inc_diagonal;
				x_major_q      <= cmd.x_major;
				x_neg_q        <= cmd.x_neg;
				color_q        <= cmd.color;
			end else begin
				busy_q  <= n_steps != '0;
				cur_x_q <= nx;
				cur_y_q <= ny;
				steps_q <= n_steps;
				err_q   <= n_err;
			end
		end
	end

	// store emitted pixel
	always_ff @(posedge clk) begin
		if (produce) begin
			pix_mem_q[pix_wr_ptr_q] <= pix;
		end
	end

	// advance pixel queue pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_wr_ptr_q <= '0;
			pix_rd_ptr_q <= '0;
			pix_count_q  <= '0;
		end else begin
			if (produce) begin
				pix_wr_ptr_q <= pix_wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				pix_rd_ptr_q <= pix_rd_ptr_q + 1'b1;
			end
			if (produce && !do_pop) begin
				pix_count_q <= pix_count_q + 1'b1;
			end else if (do_pop && !produce) begin
				pix_count_q <= pix_count_q - 1'b1;
			end
		end
	end

	// present the oldest pixel
	assign head        = pix_mem_q[pix_rd_ptr_q];
	assign pixel_x     = head.x;
	assign pixel_y     = head.y;
	assign pixel_value = head.value;
	assign last        = head.last;

endmodule

`default_nettype wire

/* rtl/line_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// line_rasterizer_core: Bresenham line rasterizer
// Queue-style input of start and step transactions, queue-style pixel output.
// ----------------------------------------------------------------------------
// A start transaction latches two endpoints and a color and yields the first
// pixel; every step transaction yields the next pixel, with last set on the
// final one, and a step while no line is active yields nothing. The block
// takes one transaction per clock and gives one pixel per clock in steady
// state while pop keeps the queues from filling: the stepper does one error
// add and compare per pixel. An accepted transaction passes the input
// register, command queue and pixel queue. No clearing pass after reset.
`default_nettype none

module line_rasterizer_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         kind,
	input  wire lr_pkg::coord_t               start_x,
	input  wire lr_pkg::coord_t               start_y,
	input  wire lr_pkg::coord_t               end_x,
	input  wire lr_pkg::coord_t               end_y,
	input  wire logic [lr_pkg::ColorBits-1:0] line_color,
	output logic                              empty,
	input  wire logic                         pop,
	output lr_pkg::coord_t                    pixel_x,
	output lr_pkg::coord_t                    pixel_y,
	output logic [lr_pkg::ColorBits-1:0]      pixel_value,
	output logic                              last
);

	logic          fe_valid;
	lr_pkg::cmd_t  fe_cmd;
	logic          fe_ready;
	logic          q_valid;
	lr_pkg::cmd_t  q_cmd;
	logic          q_rd;

	// classify and set up lines
	lr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.line_color (line_color),
		.cmd_valid  (fe_valid),
		.cmd        (fe_cmd),
		.cmd_ready  (fe_ready)
	);

	// decouple setup from stepping
	lr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fe_valid),
		.wr_data  (fe_cmd),
		.wr_ready (fe_ready),
		.rd_valid (q_valid),
		.rd_data  (q_cmd),
		.rd_en    (q_rd)
	);

	// step lines and queue pixels
	lr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (q_valid),
		.cmd         (q_cmd),
		.cmd_rd      (q_rd),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.last        (last)
	);

endmodule

`default_nettype wire
